// ----- src/hrc_pkg.sv -----
// Shared widths, constants, payload types and helpers for the hanging rectangle corner pipeline.
`default_nettype none

package hrc_pkg;

  localparam int TRIG_STAGES_DEF = 16;

  localparam int COORD_W = 32;
  localparam int LEN_W   = 31;
  localparam int TILT_W  = 16;
  localparam int DIFF_W  = 33;
  localparam int BLEN_W  = 6;
  localparam int NORM_W  = 30;
  localparam int SQ_W    = 2 * NORM_W;
  localparam int SUM_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int NUM_W   = NORM_W + 31;
  localparam int QUOT_W  = 31;
  localparam int UNIT_W  = 32;
  localparam int CS_W    = 34;
  localparam int TRIG_W  = 32;
  localparam int WIDE_W  = 37;

  localparam logic signed [CS_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CS_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [CS_W-1:0] HALF_PI_Q29 = 34'sd843314857;

  // Element payload carried alongside the arithmetic
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [LEN_W-1:0]          h;
    logic [LEN_W-1:0]          w;
    logic signed [TILT_W-1:0]  tilt;
  } pay_t;

  typedef struct packed {
    pay_t                   pay;
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   zero;
  } sq_side_t;

  typedef struct packed {
    pay_t       pay;
    logic [2:0] neg;
    logic       zero;
  } div_side_t;

  typedef struct packed {
    pay_t                   pay;
    logic [2:0][UNIT_W-1:0] u;
  } trig_side_t;

  // Arctangent of 2^-k in Q2.29
  function automatic logic signed [CS_W-1:0] atan_q29(input logic [4:0] k);
    logic signed [CS_W-1:0] a;
    begin
      case (k)
        5'd0:  a = 34'sd421657428;
        5'd1:  a = 34'sd248918915;
        5'd2:  a = 34'sd131521918;
        5'd3:  a = 34'sd66762579;
        5'd4:  a = 34'sd33510843;
        5'd5:  a = 34'sd16771758;
        5'd6:  a = 34'sd8387925;
        5'd7:  a = 34'sd4194219;
        5'd8:  a = 34'sd2097141;
        5'd9:  a = 34'sd1048575;
        5'd10: a = 34'sd524288;
        5'd11: a = 34'sd262144;
        5'd12: a = 34'sd131072;
        5'd13: a = 34'sd65536;
        5'd14: a = 34'sd32768;
        5'd15: a = 34'sd16384;
        5'd16: a = 34'sd8192;
        5'd17: a = 34'sd4096;
        5'd18: a = 34'sd2048;
        5'd19: a = 34'sd1024;
        5'd20: a = 34'sd512;
        5'd21: a = 34'sd256;
        5'd22: a = 34'sd128;
        5'd23: a = 34'sd64;
        5'd24: a = 34'sd32;
        5'd25: a = 34'sd16;
        5'd26: a = 34'sd8;
        5'd27: a = 34'sd4;
        5'd28: a = 34'sd2;
        5'd29: a = 34'sd1;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

  // Number of significant bits of a magnitude
  function automatic logic [BLEN_W-1:0] bit_len(input logic [DIFF_W-1:0] v);
    logic [BLEN_W-1:0] n;
    begin
      n = '0;
      for (int i = 0; i < DIFF_W; i++) begin
        if (v[i]) n = BLEN_W'(i + 1);
      end
      return n;
    end
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [COORD_W-1:0] r;
    begin
      if (v > 37'sd2147483647) r = 32'h7fff_ffff;
      else if (v < -37'sd2147483648) r = 32'h8000_0000;
      else r = v[COORD_W-1:0];
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/hrc_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module hrc_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [hrc_pkg::SUM_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [hrc_pkg::ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int RW    = hrc_pkg::ROOT_W;
  localparam int REM_W = RW + 3;

  logic                      vld  [RW];
  logic [REM_W-1:0]          rem  [RW];
  logic [RW-1:0]             root [RW];
  logic [hrc_pkg::SUM_W-1:0] rad  [RW];
  logic [SIDE_W-1:0]         side [RW];

  for (genvar g = 0; g < RW; g++) begin : g_step
    localparam int P = RW - 1 - g;
    logic                      p_vld;
    logic [REM_W-1:0]          p_rem;
    logic [RW-1:0]             p_root;
    logic [hrc_pkg::SUM_W-1:0] p_rad;
    logic [SIDE_W-1:0]         p_side;
    logic [REM_W-1:0]          cur;
    logic [REM_W-1:0]          trial;

    if (g == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = in_rad;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[g-1];
      assign p_rem  = rem[g-1];
      assign p_root = root[g-1];
      assign p_rad  = rad[g-1];
      assign p_side = side[g-1];
    end

    // Bring down the next bit pair and try the trial subtrahend
    always_comb begin
      cur   = {p_rem[REM_W-3:0], p_rad[2*P +: 2]};
      trial = {1'b0, p_root, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= p_vld;
      end
      rad[g]  <= p_rad;
      side[g] <= p_side;
      if (cur >= trial) begin
        rem[g]  <= cur - trial;
        root[g] <= {p_root[RW-2:0], 1'b1};
      end else begin
        rem[g]  <= cur;
        root[g] <= {p_root[RW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_side  = side[RW-1];

endmodule

`default_nettype wire

// ----- src/hrc_div.sv -----
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
`default_nettype none

module hrc_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [hrc_pkg::NUM_W-1:0]  in_num [3],
  input  logic [hrc_pkg::ROOT_W-1:0] in_den,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [hrc_pkg::QUOT_W-1:0] out_quot [3],
  output logic [SIDE_W-1:0]          out_side
);

  localparam int QW    = hrc_pkg::QUOT_W;
  localparam int DW    = hrc_pkg::ROOT_W;
  localparam int NW    = hrc_pkg::NUM_W;
  localparam int REM_W = DW + 1;

  logic             vld  [QW];
  logic [REM_W-1:0] rem  [QW][3];
  logic [NW-1:0]    num  [QW][3];
  logic [QW-1:0]    quot [QW][3];
  logic [DW-1:0]    den  [QW];
  logic [SIDE_W-1:0] side [QW];

  for (genvar g = 0; g < QW; g++) begin : g_step
    localparam int B = QW - 1 - g;
    logic              p_vld;
    logic [REM_W-1:0]  p_rem  [3];
    logic [NW-1:0]     p_num  [3];
    logic [QW-1:0]     p_quot [3];
    logic [DW-1:0]     p_den;
    logic [SIDE_W-1:0] p_side;
    logic [REM_W-1:0]  cur    [3];

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          p_rem[l]  = REM_W'(in_num[l][NW-1:QW]);
          p_num[l]  = in_num[l];
          p_quot[l] = '0;
        end
      end
      assign p_vld  = in_valid;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          p_rem[l]  = rem[g-1][l];
          p_num[l]  = num[g-1][l];
          p_quot[l] = quot[g-1][l];
        end
      end
      assign p_vld  = vld[g-1];
      assign p_den  = den[g-1];
      assign p_side = side[g-1];
    end

    // Shift in the next dividend bit per lane
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        cur[l] = {p_rem[l][REM_W-2:0], p_num[l][B]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= p_vld;
      end
      den[g]  <= p_den;
      side[g] <= p_side;
      for (int l = 0; l < 3; l++) begin
        num[g][l] <= p_num[l];
        if (cur[l] >= {1'b0, p_den}) begin
          rem[g][l]  <= cur[l] - {1'b0, p_den};
          quot[g][l] <= {p_quot[l][QW-2:0], 1'b1};
        end else begin
          rem[g][l]  <= cur[l];
          quot[g][l] <= {p_quot[l][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_side  = side[QW-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_quot[l] = quot[QW-1][l];
    end
  end

endmodule

`default_nettype wire

// ----- src/hrc_cordic.sv -----
// Pipelined rotation CORDIC giving sine and cosine of the tilt angle.
`default_nettype none

module hrc_cordic #(
  parameter int STAGES = hrc_pkg::TRIG_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [hrc_pkg::TILT_W-1:0] in_tilt,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic signed [hrc_pkg::TRIG_W-1:0] out_sin,
  output logic signed [hrc_pkg::TRIG_W-1:0] out_cos,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int W = hrc_pkg::CS_W;

  logic                r_vld;
  logic signed [W-1:0] r_ang;
  logic                r_flip;
  logic [SIDE_W-1:0]   r_side;
  logic signed [W-1:0] ang0;

  logic                vld  [STAGES];
  logic signed [W-1:0] x    [STAGES];
  logic signed [W-1:0] y    [STAGES];
  logic signed [W-1:0] ang  [STAGES];
  logic                flip [STAGES];
  logic [SIDE_W-1:0]   side [STAGES];

  // Fold the angle into the half-turn around zero
  assign ang0 = W'($signed({in_tilt, 16'b0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else begin
      r_vld <= in_valid;
    end
    r_side <= in_side;
    if (ang0 > hrc_pkg::HALF_PI_Q29) begin
      r_ang  <= ang0 - hrc_pkg::PI_Q29;
      r_flip <= 1'b1;
    end else if (ang0 < -hrc_pkg::HALF_PI_Q29) begin
      r_ang  <= ang0 + hrc_pkg::PI_Q29;
      r_flip <= 1'b1;
    end else begin
      r_ang  <= ang0;
      r_flip <= 1'b0;
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_rot
    localparam int K = g % 32;
    logic                p_vld;
    logic signed [W-1:0] p_x;
    logic signed [W-1:0] p_y;
    logic signed [W-1:0] p_ang;
    logic                p_flip;
    logic [SIDE_W-1:0]   p_side;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] at;

    if (g == 0) begin : g_first
      assign p_vld  = r_vld;
      assign p_x    = hrc_pkg::GAIN_Q30;
      assign p_y    = '0;
      assign p_ang  = r_ang;
      assign p_flip = r_flip;
      assign p_side = r_side;
    end else begin : g_next
      assign p_vld  = vld[g-1];
      assign p_x    = x[g-1];
      assign p_y    = y[g-1];
      assign p_ang  = ang[g-1];
      assign p_flip = flip[g-1];
      assign p_side = side[g-1];
    end

    assign dx = p_y >>> K;
    assign dy = p_x >>> K;
    assign at = hrc_pkg::atan_q29(5'(K));

    // Rotate towards zero residual angle
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= p_vld;
      end
      flip[g] <= p_flip;
      side[g] <= p_side;
      if (p_ang >= 0) begin
        x[g]   <= p_x - dx;
        y[g]   <= p_y + dy;
        ang[g] <= p_ang - at;
      end else begin
        x[g]   <= p_x + dx;
        y[g]   <= p_y - dy;
        ang[g] <= p_ang + at;
      end
    end
  end

  // Undo the fold and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[STAGES-1];
    end
    out_side <= side[STAGES-1];
    if (flip[STAGES-1]) begin
      out_sin <= hrc_pkg::TRIG_W'(-y[STAGES-1]);
      out_cos <= hrc_pkg::TRIG_W'(-x[STAGES-1]);
    end else begin
      out_sin <= hrc_pkg::TRIG_W'(y[STAGES-1]);
      out_cos <= hrc_pkg::TRIG_W'(x[STAGES-1]);
    end
  end

endmodule

`default_nettype wire

// ----- src/hanging_rectangle_corners.sv -----
// Hanging rectangle corners: top level of the fully pipelined corner datapath.
//
// One word is taken on every clock edge where start is high; busy stays low, so
// words may follow back to back. Each result appears on the corner ports for a
// single cycle marked by done. The path runs through the 31-stage square root and
// the 31-stage divider for the unit direction, plus the CORDIC stages for the
// tilt; results leave in input order and the receiver cannot hold them off.
`default_nettype none

module hanging_rectangle_corners #(
  parameter int TRIG_STAGES = hrc_pkg::TRIG_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [hrc_pkg::COORD_W-1:0] start_x,
  input  logic signed [hrc_pkg::COORD_W-1:0] start_y,
  input  logic signed [hrc_pkg::COORD_W-1:0] start_z,
  input  logic signed [hrc_pkg::COORD_W-1:0] end_x,
  input  logic signed [hrc_pkg::COORD_W-1:0] end_y,
  input  logic signed [hrc_pkg::COORD_W-1:0] end_z,
  input  logic signed [hrc_pkg::COORD_W-1:0] center_x,
  input  logic signed [hrc_pkg::COORD_W-1:0] center_y,
  input  logic signed [hrc_pkg::COORD_W-1:0] center_z,
  input  logic signed [hrc_pkg::TILT_W-1:0]  tilt,
  input  logic [hrc_pkg::LEN_W-1:0]          hang_length,
  input  logic [hrc_pkg::LEN_W-1:0]          span_width,
  output logic                               done,
  output logic signed [hrc_pkg::COORD_W-1:0] c0_x,
  output logic signed [hrc_pkg::COORD_W-1:0] c0_y,
  output logic signed [hrc_pkg::COORD_W-1:0] c0_z,
  output logic signed [hrc_pkg::COORD_W-1:0] c1_x,
  output logic signed [hrc_pkg::COORD_W-1:0] c1_y,
  output logic signed [hrc_pkg::COORD_W-1:0] c1_z,
  output logic signed [hrc_pkg::COORD_W-1:0] c2_x,
  output logic signed [hrc_pkg::COORD_W-1:0] c2_y,
  output logic signed [hrc_pkg::COORD_W-1:0] c2_z,
  output logic signed [hrc_pkg::COORD_W-1:0] c3_x,
  output logic signed [hrc_pkg::COORD_W-1:0] c3_y,
  output logic signed [hrc_pkg::COORD_W-1:0] c3_z
);

  localparam int CW = hrc_pkg::COORD_W;
  localparam int DW = hrc_pkg::DIFF_W;
  localparam int NW = hrc_pkg::NORM_W;
  localparam int XW = hrc_pkg::WIDE_W;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Input staging
  logic signed [CW-1:0] st_c [3];
  logic signed [CW-1:0] en_c [3];
  logic signed [DW-1:0] d_c  [3];
  hrc_pkg::pay_t        in_pay;

  always_comb begin
    st_c[0] = start_x; st_c[1] = start_y; st_c[2] = start_z;
    en_c[0] = end_x;   en_c[1] = end_y;   en_c[2] = end_z;
    for (int k = 0; k < 3; k++) begin
      d_c[k] = DW'(en_c[k]) - DW'(st_c[k]);
    end
    in_pay.cx   = center_x;
    in_pay.cy   = center_y;
    in_pay.cz   = center_z;
    in_pay.h    = hang_length;
    in_pay.w    = span_width;
    in_pay.tilt = tilt;
  end

  // Stage 1: differences to magnitudes and signs
  logic              s1_vld;
  logic [DW-1:0]     s1_mag [3];
  logic [2:0]        s1_neg;
  hrc_pkg::pay_t     s1_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
    s1_pay <= in_pay;
    for (int k = 0; k < 3; k++) begin
      s1_neg[k] <= d_c[k][DW-1];
      s1_mag[k] <= d_c[k][DW-1] ? DW'(-d_c[k]) : DW'(d_c[k]);
    end
  end

  // Stage 2: common bit length
  logic                       s2_vld;
  logic [DW-1:0]              s2_mag [3];
  logic [2:0]                 s2_neg;
  logic                       s2_zero;
  logic [hrc_pkg::BLEN_W-1:0] s2_len;
  hrc_pkg::pay_t              s2_pay;
  logic [DW-1:0]              mag_or;

  assign mag_or = s1_mag[0] | s1_mag[1] | s1_mag[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_pay  <= s1_pay;
    s2_neg  <= s1_neg;
    s2_mag  <= s1_mag;
    s2_zero <= (mag_or == '0);
    s2_len  <= hrc_pkg::bit_len(mag_or);
  end

  // Stage 3: normalise so the largest magnitude tops out at bit 29
  logic              s3_vld;
  logic [NW-1:0]     s3_mag [3];
  logic [2:0]        s3_neg;
  logic              s3_zero;
  hrc_pkg::pay_t     s3_pay;
  logic [DW-1:0]     shifted [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s2_len > hrc_pkg::BLEN_W'(NW)) begin
        shifted[k] = s2_mag[k] >> (s2_len - hrc_pkg::BLEN_W'(NW));
      end else begin
        shifted[k] = s2_mag[k] << (hrc_pkg::BLEN_W'(NW) - s2_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_pay  <= s2_pay;
    s3_neg  <= s2_neg;
    s3_zero <= s2_zero;
    for (int k = 0; k < 3; k++) begin
      s3_mag[k] <= shifted[k][NW-1:0];
    end
  end

  // Stage 4: squares
  logic                     s4_vld;
  logic [hrc_pkg::SQ_W-1:0] s4_sq [3];
  hrc_pkg::sq_side_t        s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_side.pay  <= s3_pay;
    s4_side.neg  <= s3_neg;
    s4_side.zero <= s3_zero;
    for (int k = 0; k < 3; k++) begin
      s4_side.mag[k] <= s3_mag[k];
      s4_sq[k] <= hrc_pkg::SQ_W'(s3_mag[k]) * hrc_pkg::SQ_W'(s3_mag[k]);
    end
  end

  // Stage 5: sum of squares
  logic                      s5_vld;
  logic [hrc_pkg::SUM_W-1:0] s5_sum;
  hrc_pkg::sq_side_t         s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_side <= s4_side;
    s5_sum  <= hrc_pkg::SUM_W'(s4_sq[0]) + hrc_pkg::SUM_W'(s4_sq[1])
             + hrc_pkg::SUM_W'(s4_sq[2]);
  end

  // Norm
  logic                       sq_vld;
  logic [hrc_pkg::ROOT_W-1:0] sq_root;
  hrc_pkg::sq_side_t          sq_side;

  hrc_isqrt #(
    .SIDE_W ($bits(hrc_pkg::sq_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_vld),
    .in_rad    (s5_sum),
    .in_side   (s5_side),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage 6: rounded dividends
  logic                       s6_vld;
  logic [hrc_pkg::NUM_W-1:0]  s6_num [3];
  logic [hrc_pkg::ROOT_W-1:0] s6_den;
  hrc_pkg::div_side_t         s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= sq_vld;
    end
    s6_den       <= sq_root;
    s6_side.pay  <= sq_side.pay;
    s6_side.neg  <= sq_side.neg;
    s6_side.zero <= sq_side.zero;
    for (int k = 0; k < 3; k++) begin
      s6_num[k] <= hrc_pkg::NUM_W'({sq_side.mag[k], 30'b0})
                 + hrc_pkg::NUM_W'(sq_root >> 1);
    end
  end

  // Unit direction
  logic                       dv_vld;
  logic [hrc_pkg::QUOT_W-1:0] dv_quot [3];
  hrc_pkg::div_side_t         dv_side;
  hrc_pkg::trig_side_t        tr_in;

  hrc_div #(
    .SIDE_W ($bits(hrc_pkg::div_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_vld),
    .in_num    (s6_num),
    .in_den    (s6_den),
    .in_side   (s6_side),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // Apply signs; coincident endpoints give a zero direction
  always_comb begin
    tr_in.pay = dv_side.pay;
    for (int k = 0; k < 3; k++) begin
      if (dv_side.zero) begin
        tr_in.u[k] = '0;
      end else if (dv_side.neg[k]) begin
        tr_in.u[k] = hrc_pkg::UNIT_W'(-hrc_pkg::UNIT_W'(dv_quot[k]));
      end else begin
        tr_in.u[k] = hrc_pkg::UNIT_W'(dv_quot[k]);
      end
    end
  end

  // Tilt
  logic                              tr_vld;
  logic signed [hrc_pkg::TRIG_W-1:0] tr_sin;
  logic signed [hrc_pkg::TRIG_W-1:0] tr_cos;
  hrc_pkg::trig_side_t               tr_side;

  hrc_cordic #(
    .STAGES (TRIG_STAGES),
    .SIDE_W ($bits(hrc_pkg::trig_side_t))
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_vld),
    .in_tilt   (dv_side.pay.tilt),
    .in_side   (tr_in),
    .out_valid (tr_vld),
    .out_sin   (tr_sin),
    .out_cos   (tr_cos),
    .out_side  (tr_side)
  );

  // P1: scale by length and half width
  logic signed [63:0]   hs_p;
  logic signed [63:0]   hc_p;
  logic signed [63:0]   hw_p [3];
  logic signed [63:0]   hs_r;
  logic signed [63:0]   hc_r;
  logic signed [63:0]   hw_r [3];

  logic                 p1_vld;
  logic signed [33:0]   p1_hs;
  logic signed [33:0]   p1_hc;
  logic signed [32:0]   p1_hw [3];
  logic signed [CW-1:0] p1_ctr [3];
  logic signed [hrc_pkg::UNIT_W-1:0] p1_ux;
  logic signed [hrc_pkg::UNIT_W-1:0] p1_uy;

  always_comb begin
    hs_p = $signed({1'b0, tr_side.pay.h}) * tr_sin;
    hc_p = $signed({1'b0, tr_side.pay.h}) * tr_cos;
    hs_r = hs_p + 64'sd536870912;
    hc_r = hc_p + 64'sd536870912;
    for (int k = 0; k < 3; k++) begin
      hw_p[k] = $signed({1'b0, tr_side.pay.w}) * $signed(tr_side.u[k]);
      hw_r[k] = hw_p[k] + 64'sd1073741824;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= tr_vld;
    end
    p1_hs     <= hs_r[63:30];
    p1_hc     <= hc_r[63:30];
    p1_ux     <= $signed(tr_side.u[0]);
    p1_uy     <= $signed(tr_side.u[1]);
    p1_ctr[0] <= tr_side.pay.cx;
    p1_ctr[1] <= tr_side.pay.cy;
    p1_ctr[2] <= tr_side.pay.cz;
    for (int k = 0; k < 3; k++) begin
      p1_hw[k] <= hw_r[k][63:31];
    end
  end

  // P2: drop offsets and top corners
  logic signed [65:0]   ox_p;
  logic signed [65:0]   oy_p;
  logic signed [65:0]   ox_r;
  logic signed [65:0]   oy_r;

  logic                 p2_vld;
  logic signed [35:0]   p2_off  [3];
  logic signed [33:0]   p2_top0 [3];
  logic signed [33:0]   p2_top1 [3];

  always_comb begin
    ox_p = p1_hs * p1_uy;
    oy_p = p1_hs * p1_ux;
    ox_r = ox_p + 66'sd536870912;
    oy_r = oy_p + 66'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
    p2_off[0] <= ox_r[65:30];
    p2_off[1] <= -oy_r[65:30];
    p2_off[2] <= -36'(p1_hc);
    for (int k = 0; k < 3; k++) begin
      p2_top0[k] <= 34'(p1_ctr[k]) - 34'(p1_hw[k]);
      p2_top1[k] <= 34'(p1_ctr[k]) + 34'(p1_hw[k]);
    end
  end

  // P3: bottom corners, clamp, present
  logic [CW-1:0] res [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res[0][k] = hrc_pkg::sat32(XW'(p2_top0[k]));
      res[1][k] = hrc_pkg::sat32(XW'(p2_top1[k]));
      res[2][k] = hrc_pkg::sat32(XW'(p2_top1[k]) + XW'(p2_off[k]));
      res[3][k] = hrc_pkg::sat32(XW'(p2_top0[k]) + XW'(p2_off[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p2_vld;
    end
    c0_x <= res[0][0]; c0_y <= res[0][1]; c0_z <= res[0][2];
    c1_x <= res[1][0]; c1_y <= res[1][1]; c1_z <= res[1][2];
    c2_x <= res[2][0]; c2_y <= res[2][1]; c2_z <= res[2][2];
    c3_x <= res[3][0]; c3_y <= res[3][1]; c3_z <= res[3][2];
  end

endmodule

`default_nettype wire
